### rtl/gspc_pkg.sv
// shared types, constants and register codes of the gaussian skin pixel classifier
package gspc_pkg;

  localparam int COUNT_BITS = 22;
  localparam int OUT_W      = 22;
  localparam int PIX_W      = 8;
  localparam int CHROMA_W   = 17;
  localparam int DIFF_W     = 18;
  localparam int PROD_W     = 36;
  localparam int MUL_X_W    = 19;
  localparam int MUL_Y_W    = 34;
  localparam int MUL_P_W    = MUL_X_W + MUL_Y_W;
  localparam int ACC_W      = 70;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_COV_00  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_COV_01  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_COV_11  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd6;

  // chroma word handed from front to back
  typedef struct packed {
    logic signed [CHROMA_W-1:0] c0;
    logic signed [CHROMA_W-1:0] c1;
    logic                       ref_skin;
    logic                       frame_start;
  } chroma_t;

  // model settings used by the back end
  typedef struct packed {
    logic signed [15:0] mean_first;
    logic signed [15:0] mean_second;
    logic signed [31:0] inv_cov_00;
    logic signed [31:0] inv_cov_01;
    logic signed [31:0] inv_cov_11;
    logic signed [31:0] threshold;
  } model_cfg_t;

endpackage

### rtl/gspc_front.sv
// front end: takes pixels and forms the chroma word (rg divider or cbcr)
module gspc_front import gspc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic             ref_is_skin_i,
  input  logic             frame_start_i,
  output logic             q_wr_o,
  output chroma_t          q_data_o,
  input  logic             q_full_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  cnt_q;
  logic [PIX_W-1:0] r_q, g_q, b_q;
  logic        ref_q, start_q;
  logic [9:0]  sum_q;
  logic [15:0] num0_q, num1_q;
  logic [10:0] rem0_q, rem1_q;
  logic [8:0]  quo0_q, quo1_q;
  logic [10:0] sh0, sh1;
  logic        ge0, ge1;
  logic        accept;
  logic signed [25:0] cb_acc, cr_acc;
  logic signed [CHROMA_W-1:0] cb, cr;

  assign accept = push && !full;
  assign full   = (state_q != ST_IDLE);
  assign q_wr_o = (state_q == ST_DONE) && !q_full_i;

  // one restoring step per cycle for both components
  assign sh0 = {rem0_q[9:0], num0_q[15]};
  assign sh1 = {rem1_q[9:0], num1_q[15]};
  assign ge0 = sh0 >= {1'b0, sum_q};
  assign ge1 = sh1 >= {1'b0, sum_q};

  // cbcr with rounding to q8.8
  always_comb begin
    cb_acc = 26'(b_q) * 26'd32768 - 26'(r_q) * 26'd11076 - 26'(g_q) * 26'd21692 + 26'sd128;
    cr_acc = 26'(r_q) * 26'd32768 - 26'(g_q) * 26'd27460 - 26'(b_q) * 26'd5308 + 26'sd128;
    cb     = cb_acc[24:8];
    cr     = cr_acc[24:8];
  end

  always_comb begin
    q_data_o.ref_skin    = ref_q;
    q_data_o.frame_start = start_q;
    if (mode_i) begin
      q_data_o.c0 = cb;
      q_data_o.c1 = cr;
    end else if (sum_q == 10'd0) begin
      q_data_o.c0 = '0;
      q_data_o.c1 = '0;
    end else begin
      q_data_o.c0 = {8'b0, quo0_q};
      q_data_o.c1 = {8'b0, quo1_q};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = mode_i ? ST_DONE : ST_CALC;
      ST_CALC: if (cnt_q == 4'd15) state_d = ST_DONE;
      ST_DONE: if (!q_full_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= '0;
      else if (state_q == ST_CALC) cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q     <= red_i;
      g_q     <= green_i;
      b_q     <= blue_i;
      ref_q   <= ref_is_skin_i;
      start_q <= frame_start_i;
      sum_q   <= 10'(red_i) + 10'(green_i) + 10'(blue_i);
      num0_q  <= {red_i, 8'b0};
      num1_q  <= {green_i, 8'b0};
      rem0_q  <= '0;
      rem1_q  <= '0;
      quo0_q  <= '0;
      quo1_q  <= '0;
    end else if (state_q == ST_CALC) begin
      num0_q <= {num0_q[14:0], 1'b0};
      num1_q <= {num1_q[14:0], 1'b0};
      rem0_q <= ge0 ? sh0 - {1'b0, sum_q} : sh0;
      rem1_q <= ge1 ? sh1 - {1'b0, sum_q} : sh1;
      quo0_q <= {quo0_q[7:0], ge0};
      quo1_q <= {quo1_q[7:0], ge1};
    end
  end

endmodule

### rtl/gspc_queue.sv
// two-entry queue of chroma words between front and back
module gspc_queue import gspc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  chroma_t wr_data_i,
  output logic    full_o,
  input  logic    rd_i,
  output chroma_t rd_data_o,
  output logic    empty_o
);

  chroma_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= !wr_ptr_q;
      if (rd_i) rd_ptr_q <= !rd_ptr_q;
      if (wr_i && !rd_i) count_q <= count_q + 2'd1;
      else if (rd_i && !wr_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

### rtl/gspc_back.sv
// back end: quadratic form on a shared multiplier, decision, counters, result register
module gspc_back import gspc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  model_cfg_t       cfg_i,
  input  chroma_t          q_data_i,
  input  logic             q_empty_i,
  output logic             q_rd_o,
  output logic             empty,
  input  logic             pop,
  output logic             is_skin_o,
  output logic [OUT_W-1:0] skin_total_o,
  output logic [OUT_W-1:0] non_skin_total_o,
  output logic [OUT_W-1:0] missed_skin_o,
  output logic [OUT_W-1:0] false_skin_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] term_q, phase_q;
  logic signed [DIFF_W-1:0] d0_q, d1_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic ref_q, start_q;
  logic [COUNT_BITS-1:0] skin_q, non_q, miss_q, false_q;
  logic [COUNT_BITS-1:0] skin_b, non_b, miss_b, false_b;
  logic out_valid_q, load, skin;
  logic signed [MUL_X_W-1:0] mx;
  logic signed [MUL_Y_W-1:0] my, coef;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [DIFF_W-1:0]  da, db;
  logic signed [ACC_W-1:0]   prod_ext;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (&c) ? c : c + 1'b1;
  endfunction

  assign q_rd_o = (state_q == ST_IDLE) && !q_empty_i;
  assign skin   = acc_q[ACC_W-1];
  assign load   = (state_q == ST_FIN) && (!out_valid_q || pop);
  assign empty  = !out_valid_q;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (term_q)
      2'd0:    begin da = d0_q; db = d0_q; coef = MUL_Y_W'(cfg_i.inv_cov_00); end
      2'd1:    begin
        da = d0_q; db = d1_q; coef = MUL_Y_W'($signed({cfg_i.inv_cov_01, 1'b0}));
      end
      default: begin da = d1_q; db = d1_q; coef = MUL_Y_W'(cfg_i.inv_cov_11); end
    endcase
    unique case (phase_q)
      2'd0:    begin mx = MUL_X_W'(da); my = MUL_Y_W'(db); end
      2'd1:    begin mx = $signed({1'b0, p_q[17:0]}); my = coef; end
      default: begin mx = MUL_X_W'($signed(p_q[PROD_W-1:18])); my = coef; end
    endcase
    prod     = mx * my;
    prod_ext = ACC_W'(prod);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_rd_o) state_d = ST_RUN;
      ST_RUN:  if (term_q == 2'd2 && phase_q == 2'd2) state_d = ST_FIN;
      ST_FIN:  if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // counters after this pixel, frame start clears first
  always_comb begin
    skin_b  = start_q ? '0 : skin_q;
    non_b   = start_q ? '0 : non_q;
    miss_b  = start_q ? '0 : miss_q;
    false_b = start_q ? '0 : false_q;
    if (skin) skin_b = bump(skin_b);
    else non_b = bump(non_b);
    if (ref_q && !skin) miss_b = bump(miss_b);
    if (!ref_q && skin) false_b = bump(false_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      skin_q      <= '0;
      non_q       <= '0;
      miss_q      <= '0;
      false_q     <= '0;
    end else begin
      state_q <= state_d;
      if (q_rd_o) begin
        term_q  <= '0;
        phase_q <= '0;
      end else if (state_q == ST_RUN) begin
        if (phase_q == 2'd2) begin
          phase_q <= '0;
          term_q  <= term_q + 2'd1;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
        skin_q      <= skin_b;
        non_q       <= non_b;
        miss_q      <= miss_b;
        false_q     <= false_b;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      d0_q    <= DIFF_W'(q_data_i.c0) - DIFF_W'(cfg_i.mean_first);
      d1_q    <= DIFF_W'(q_data_i.c1) - DIFF_W'(cfg_i.mean_second);
      acc_q   <= ACC_W'(cfg_i.threshold) <<< 17;
      ref_q   <= q_data_i.ref_skin;
      start_q <= q_data_i.frame_start;
    end else if (state_q == ST_RUN) begin
      unique case (phase_q)
        2'd0:    p_q   <= prod[PROD_W-1:0];
        2'd1:    acc_q <= acc_q + prod_ext;
        default: acc_q <= acc_q + (prod_ext <<< 18);
      endcase
    end
    if (load) begin
      is_skin_o        <= skin;
      skin_total_o     <= OUT_W'(skin_b);
      non_skin_total_o <= OUT_W'(non_b);
      missed_skin_o    <= OUT_W'(miss_b);
      false_skin_o     <= OUT_W'(false_b);
    end
  end

endmodule

### rtl/gaussian_skin_pixel_classifier.sv
// top level of the gaussian skin pixel classifier
//
//  channel | handshake                     | payload
//  --------+-------------------------------+------------------------------------------
//  input   | push / full                   | red_i green_i blue_i ref_is_skin_i frame_start_i
//  result  | empty / pop                   | is_skin_o skin_total_o non_skin_total_o
//          |                               | missed_skin_o false_skin_o
//  config  | cfg_valid_i / cfg_ready_o     | cfg_index_i cfg_data_i
//
// pace: in cbcr mode the back end sets the pace of words, walking the
//   three terms of the quadratic form in three steps each on one 19x34 multiplier
// in rg mode the restoring divider of the front end sets the pace instead
// reset clears control state and counters and loads the register reset values
// a two-entry queue sits between front and back, and the result register lets the
//   back end finish the next word while the previous one waits to be popped
module gaussian_skin_pixel_classifier import gspc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      blue_i,
  input  logic                  ref_is_skin_i,
  input  logic                  frame_start_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  is_skin_o,
  output logic [OUT_W-1:0]      skin_total_o,
  output logic [OUT_W-1:0]      non_skin_total_o,
  output logic [OUT_W-1:0]      missed_skin_o,
  output logic [OUT_W-1:0]      false_skin_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       mode_q;
  model_cfg_t cfg_q;
  logic       cfg_wr;

  // front to queue, queue to back
  logic    q_wr, q_full, q_rd, q_empty;
  chroma_t q_wdata, q_rdata;

  // config writes are always taken, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q            <= 1'b0;
      cfg_q.mean_first  <= '0;
      cfg_q.mean_second <= '0;
      cfg_q.inv_cov_00  <= 32'sd65536;
      cfg_q.inv_cov_01  <= '0;
      cfg_q.inv_cov_11  <= 32'sd65536;
      cfg_q.threshold   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_CHROMA_MODE: mode_q            <= cfg_data_i[0];
        REG_MEAN_FIRST:  cfg_q.mean_first  <= cfg_data_i[15:0];
        REG_MEAN_SECOND: cfg_q.mean_second <= cfg_data_i[15:0];
        REG_INV_COV_00:  cfg_q.inv_cov_00  <= cfg_data_i;
        REG_INV_COV_01:  cfg_q.inv_cov_01  <= cfg_data_i;
        REG_INV_COV_11:  cfg_q.inv_cov_11  <= cfg_data_i;
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chroma formation
  gspc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .push          (push),
    .full          (full),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .ref_is_skin_i (ref_is_skin_i),
    .frame_start_i (frame_start_i),
    .q_wr_o        (q_wr),
    .q_data_o      (q_wdata),
    .q_full_i      (q_full)
  );

  // decoupling queue
  gspc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  // decision and counting
  gspc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_data_i         (q_rdata),
    .q_empty_i        (q_empty),
    .q_rd_o           (q_rd),
    .empty            (empty),
    .pop              (pop),
    .is_skin_o        (is_skin_o),
    .skin_total_o     (skin_total_o),
    .non_skin_total_o (non_skin_total_o),
    .missed_skin_o    (missed_skin_o),
    .false_skin_o     (false_skin_o)
  );

endmodule

### bench/gaussian_skin_pixel_classifier_tb.sv
// self-checking testbench of the gaussian skin pixel classifier
`timescale 1ns / 100ps

module gaussian_skin_pixel_classifier_tb;
  import gspc_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_WORDS    = 1150;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // one pixel word and one classification word
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             ref_skin;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic             skin;
    logic [OUT_W-1:0] skin_total;
    logic [OUT_W-1:0] non_skin_total;
    logic [OUT_W-1:0] missed;
    logic [OUT_W-1:0] false_hits;
  } verdict_t;

  // directed row: pixel plus an optional typed-in verdict
  typedef struct packed {
    pixel_t   pix;
    logic     has_verdict;
    verdict_t verdict;
  } pixel_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [PIX_W-1:0]      red_i, green_i, blue_i;
  logic                  ref_is_skin_i, frame_start_i;
  logic                  empty;
  logic                  pop;
  logic                  is_skin_o;
  logic [OUT_W-1:0]      skin_total_o, non_skin_total_o, missed_skin_o, false_skin_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gaussian_skin_pixel_classifier uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the classifier settings and counters
  logic                   mode_cbcr;
  logic signed [15:0]     mean0, mean1;
  logic signed [31:0]     icov00, icov01, icov11, thresh;
  logic [COUNT_BITS-1:0]  cnt_skin, cnt_non, cnt_missed, cnt_false;

  verdict_t verdict_queue[$];
  int       error_count;
  int       idle_cycles = 0;
  bit       pop_gaps_on;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (c == COUNT_FULL) ? c : c + 1'b1;
  endfunction

  // chroma to q8.8 with round half up, floor division
  function automatic longint round_q88(longint acc);
    return (acc + 128) >>> 8;
  endfunction

  // classify one pixel and advance the counters
  function automatic verdict_t classify_pixel(pixel_t p);
    longint r, g, b, sum, c0, c1, d0, d1;
    logic signed [127:0] q;
    logic skin;
    verdict_t v;
    r = p.red; g = p.green; b = p.blue;
    if (!mode_cbcr) begin
      sum = r + g + b;
      c0 = (sum > 0) ? (r * 256) / sum : 0;
      c1 = (sum > 0) ? (g * 256) / sum : 0;
    end else begin
      c0 = round_q88(-11076 * r - 21692 * g + 32768 * b);
      c1 = round_q88(32768 * r - 27460 * g - 5308 * b);
    end
    d0 = c0 - longint'(mean0);
    d1 = c1 - longint'(mean1);
    q = 128'(signed'(d0 * d0)) * 128'(signed'(longint'(icov00)))
      + 128'(signed'(d0 * d1)) * 128'(signed'(2 * longint'(icov01)))
      + 128'(signed'(d1 * d1)) * 128'(signed'(longint'(icov11)))
      + 128'(signed'(longint'(thresh) * 131072));
    skin = q[127];
    if (p.frame_start) begin
      cnt_skin = '0; cnt_non = '0; cnt_missed = '0; cnt_false = '0;
    end
    if (skin) cnt_skin = sat_inc(cnt_skin);
    else      cnt_non  = sat_inc(cnt_non);
    if (p.ref_skin && !skin) cnt_missed = sat_inc(cnt_missed);
    if (!p.ref_skin && skin) cnt_false  = sat_inc(cnt_false);
    v.skin           = skin;
    v.skin_total     = cnt_skin[OUT_W-1:0];
    v.non_skin_total = cnt_non[OUT_W-1:0];
    v.missed         = cnt_missed[OUT_W-1:0];
    v.false_hits     = cnt_false[OUT_W-1:0];
    return v;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CHROMA_MODE: mode_cbcr = data[0];
      REG_MEAN_FIRST:  mean0     = data[15:0];
      REG_MEAN_SECOND: mean1     = data[15:0];
      REG_INV_COV_00:  icov00    = data;
      REG_INV_COV_01:  icov01    = data;
      REG_INV_COV_11:  icov11    = data;
      REG_THRESHOLD:   thresh    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // send one pixel word, queueing its prediction or the typed-in verdict;
  // push stays high after the handshake so words can follow back to back
  task automatic send_pixel(pixel_t p, logic has_verdict, verdict_t typed);
    verdict_t predicted;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    red_i         <= p.red;
    green_i       <= p.green;
    blue_i        <= p.blue;
    ref_is_skin_i <= p.ref_skin;
    frame_start_i <= p.frame_start;
    do @(posedge clk_i); while (full);
    predicted = classify_pixel(p);
    verdict_queue.insert(verdict_queue.size(), has_verdict ? typed : predicted);
  endtask

  // wait for all words back, then cover a word still in flight
  task automatic drain();
    push <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.red   = $urandom;
    p.green = $urandom;
    p.blue  = $urandom;
    // bias toward skin-like tones and dark pixels
    if (kind < 3) begin
      p.red   = $urandom_range(120, 255);
      p.green = $urandom_range(60, 200);
      p.blue  = $urandom_range(30, 170);
    end else if (kind == 3) begin
      p.red = $urandom_range(0, 2); p.green = $urandom_range(0, 2); p.blue = $urandom_range(0, 2);
    end
    p.ref_skin    = $urandom;
    p.frame_start = ($urandom_range(0, 63) == 0);
    return p;
  endfunction

  // config set: skin gaussian around a tone, with threshold
  task automatic load_model(logic cbcr, logic [15:0] m0, logic [15:0] m1,
                            logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] t);
    write_register(REG_CHROMA_MODE, {31'($urandom), cbcr});
    write_register(REG_MEAN_FIRST,  {16'($urandom), m0});
    write_register(REG_MEAN_SECOND, {16'($urandom), m1});
    write_register(REG_INV_COV_00,  a);
    write_register(REG_INV_COV_01,  b);
    write_register(REG_INV_COV_11,  c);
    write_register(REG_THRESHOLD,   t);
  endtask

  pixel_row_t directed_rows[$];

  function automatic pixel_row_t row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic ref_skin, logic start,
                                     logic has_verdict = 1'b0, verdict_t v = '0);
    pixel_row_t x;
    x.pix = '{red: r, green: g, blue: b, ref_skin: ref_skin, frame_start: start};
    x.has_verdict = has_verdict;
    x.verdict = v;
    return x;
  endfunction

  // result side: random pop gaps, field by field check
  initial begin
    int gap;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (verdict_queue.size() == 0) begin
          $error("word popped with no expectation waiting");
          error_count++;
        end else begin
          verdict_t want;
          want = verdict_queue.pop_front();
          if (is_skin_o !== want.skin) begin
            $error("is_skin: expected %0d actual %0d", want.skin, is_skin_o); error_count++;
          end
          if (skin_total_o !== want.skin_total) begin
            $error("skin_total: expected %0d actual %0d", want.skin_total, skin_total_o);
            error_count++;
          end
          if (non_skin_total_o !== want.non_skin_total) begin
            $error("non_skin_total: expected %0d actual %0d",
                   want.non_skin_total, non_skin_total_o);
            error_count++;
          end
          if (missed_skin_o !== want.missed) begin
            $error("missed_skin: expected %0d actual %0d", want.missed, missed_skin_o);
            error_count++;
          end
          if (false_skin_o !== want.false_hits) begin
            $error("false_skin: expected %0d actual %0d", want.false_hits, false_skin_o);
            error_count++;
          end
        end
      end
      // a stretch of back-to-back pops now and then
      if (!pop_gaps_on || $urandom_range(0, 99) < 55) pop <= 1'b1;
      else begin
        gap = pick_gap();
        if (gap == 0) pop <= 1'b1;
        else begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
          pop <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    verdict_t v;
    error_count = 0;
    pop_gaps_on = 1'b1;
    push <= 1'b0; red_i <= '0; green_i <= '0; blue_i <= '0;
    ref_is_skin_i <= 1'b0; frame_start_i <= 1'b0;
    cfg_valid_i <= 1'b0; cfg_index_i <= REG_CHROMA_MODE; cfg_data_i <= '0;
    rst_ni <= 1'b0;
    // shadow of the reset values
    mode_cbcr = 1'b0; mean0 = '0; mean1 = '0;
    icov00 = 32'sd65536; icov01 = '0; icov11 = 32'sd65536; thresh = '0;
    cnt_skin = '0; cnt_non = '0; cnt_missed = '0; cnt_false = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: rg mode, zero mean, unit covariance, zero threshold.
    // a black pixel lands exactly on the mean, quadratic form 0, not below 0, so not skin
    v = '{skin: 1'b0, skin_total: 0, non_skin_total: 1, missed: 1, false_hits: 0};
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, v));
    v = '{skin: 1'b0, skin_total: 0, non_skin_total: 2, missed: 1, false_hits: 0};
    directed_rows.insert(directed_rows.size(),
                         row(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, v));
    // frame start clears the counters before counting
    v = '{skin: 1'b0, skin_total: 0, non_skin_total: 1, missed: 0, false_hits: 0};
    directed_rows.insert(directed_rows.size(), row(8'd255, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1, v));
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd255, 8'd0, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd1, 8'd0, 8'd0, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd200, 8'd150, 8'd120, 1'b1, 1'b0));
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, directed_rows[i].has_verdict, directed_rows[i].verdict);
    drain();

    // large positive threshold: every pixel comes out non-skin; extremes in cbcr mode
    load_model(1'b1, 16'h8000, 16'h7fff, 32'h0000_0001, 32'h0, 32'h0000_0001, 32'h7fff_ffff);
    directed_rows.delete();
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    directed_rows.insert(directed_rows.size(), row(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd255, 8'd0, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'd0, 8'd255, 8'd255, 1'b1, 1'b0));
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, 1'b0, '0);
    drain();

    // extreme covariance and unknown register index, which must be ignored
    load_model(1'b1, 16'h7fff, 16'h8000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000);
    write_register(REG_UNUSED, 32'hffff_ffff);
    for (int i = 0; i < 8; i++) send_pixel(random_pixel(), 1'b0, '0);
    drain();

    // random part in phases, each a different model; no pop gaps in one phase
    for (int phase = 0; phase < 6; phase++) begin
      logic cbcr;
      cbcr = phase[0];
      pop_gaps_on = (phase != 2);
      if (phase == 5)
        load_model(1'b0, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom, $urandom);
      else if (cbcr)
        // skin around cb -0.15, cr 0.15 with modest spread
        load_model(1'b1, 16'(-38 + $signed($urandom_range(0, 20)) - 10),
                   16'(38 + $urandom_range(0, 20) - 10),
                   32'd65536 * $urandom_range(20, 200), 32'($signed($urandom_range(0, 4000)) - 2000),
                   32'd65536 * $urandom_range(20, 200), -32'sd65536 * $urandom_range(1, 20));
      else
        // skin around r 0.45, g 0.32
        load_model(1'b0, 16'(115 + $urandom_range(0, 10) - 5), 16'(82 + $urandom_range(0, 10) - 5),
                   32'd65536 * $urandom_range(10, 100), 32'($signed($urandom_range(0, 4000)) - 2000),
                   32'd65536 * $urandom_range(10, 100), -32'sd65536 * $urandom_range(1, 30));
      for (int i = 0; i < RANDOM_WORDS / 6; i++) send_pixel(random_pixel(), 1'b0, '0);
      drain();
    end
    pop_gaps_on = 1'b1;

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/gspc_pkg.sv
rtl/gspc_front.sv
rtl/gspc_queue.sv
rtl/gspc_back.sv
rtl/gaussian_skin_pixel_classifier.sv
bench/gaussian_skin_pixel_classifier_tb.sv
